@@ rtl/tspq_pkg.sv @@
// ----------------------------------------------------------------------------
// Timed sound playback queue package
// Shared widths, command and status codes, and the types that pass
// between the queue storage and the top level.
// ----------------------------------------------------------------------------
package tspq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned DELAY_W     = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_TICK = 2'd1,
    CMD_STOP = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ADD_NONE = 2'd0,
    ADD_OK   = 2'd1,
    ADD_FULL = 2'd2
  } add_status_e;

  // One queued request: address in the low bits, delay above it.
  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic [ADDR_W-1:0]  addr;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    entry_t           entry;
  } in_item_t;

  // Result item, listed from the highest field down.
  typedef struct packed {
    logic              queue_nonempty;
    logic              stop_all;
    logic [ADDR_W-1:0] start_address;
    logic              start_valid;
    add_status_e       add_status;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

  typedef struct packed {
    logic nonempty;
    logic full;
    logic last;
  } q_status_t;

endpackage

@@ rtl/tspq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tspq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/tspq_queue.sv @@
// ----------------------------------------------------------------------------
// Request queue
// Ring of entries in a RAM with read and write pointers and an entry count.
// The RAM is read every cycle at the next head pointer, so the head entry
// is ready as registered data when the next item is processed.
// ----------------------------------------------------------------------------
module tspq_queue #(
  parameter int unsigned DEPTH = tspq_pkg::QUEUE_DEPTH,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tspq_pkg::entry_t    push_entry_i,
  input  logic                pop_i,
  output tspq_pkg::entry_t    head_o,
  output tspq_pkg::q_status_t status_o
);

  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic             byp_vld_q;
  tspq_pkg::entry_t byp_entry_q;
  logic [tspq_pkg::ENTRY_W-1:0] ram_rdata;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      cnt_d    = cnt_q + 1'b1;
    end else if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      cnt_d    = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      cnt_q     <= '0;
      byp_vld_q <= 1'b0;
    end else begin
      rd_ptr_q  <= rd_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      cnt_q     <= cnt_d;
      // A write to the slot being read returns the old contents, so the
      // new entry is forwarded for the next cycle.
      byp_vld_q <= push_i && (wr_ptr_q == rd_ptr_d);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_entry_q <= push_entry_i;
  end

  tspq_ram #(
    .WIDTH (tspq_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push_i),
    .waddr_i (wr_ptr_q),
    .wdata_i (push_entry_i),
    .raddr_i (rd_ptr_d),
    .rdata_o (ram_rdata)
  );

  assign head_o = byp_vld_q ? byp_entry_q : tspq_pkg::entry_t'(ram_rdata);

  assign status_o.nonempty = (cnt_q != '0);
  assign status_o.full     = (cnt_q == CNT_W'(DEPTH));
  assign status_o.last     = (cnt_q == CNT_W'(1));

endmodule

@@ rtl/timed_sound_playback_queue.sv @@
// ----------------------------------------------------------------------------
// Timed sound playback queue
// Queues sound requests and starts them on ticks once the delay of the
// previously started sound has elapsed.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output side is not
// stalled and returns exactly one result item for each; an accepted item
// passes through the input register and then the result register.
// An add stores the address and delay if fewer than QUEUE_DEPTH requests
// are waiting, a tick advances the elapsed counter and may start the head
// request, and a stop only raises stop_all. Requests live in a RAM whose
// read port is addressed with the next head pointer every cycle, so the
// head is always ready for the following item without extra latency.
// No clearing pass is needed after reset.
module timed_sound_playback_queue #(
  parameter int unsigned QUEUE_DEPTH = tspq_pkg::QUEUE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [31:0] sound_address, [47:32] delay_after
  input  logic [tspq_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // [1:0] cmd
  input  logic [tspq_pkg::CMD_W-1:0]         s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [1:0] add_status, [2] start_valid, [34:3] start_address, [35] stop_all,
  // [36] queue_nonempty, [39:37] zero
  output logic [tspq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);

  logic               in_vld_q;
  tspq_pkg::in_item_t in_q;
  logic               out_vld_q;
  tspq_pkg::result_t  out_q, res_d;
  logic               fire;

  logic [tspq_pkg::DELAY_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [tspq_pkg::DELAY_W-1:0] cur_delay_q, cur_delay_d;

  logic                push, pop;
  tspq_pkg::entry_t    head;
  tspq_pkg::q_status_t q_status;

  assign fire            = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q.cmd   <= s_axis_tuser_i;
      in_q.entry <= tspq_pkg::entry_t'(s_axis_tdata_i);
    end
  end

  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;

  always_comb begin
    push        = 1'b0;
    pop         = 1'b0;
    elapsed_d   = elapsed_q;
    cur_delay_d = cur_delay_q;
    res_d       = '0;
    res_d.add_status = tspq_pkg::ADD_NONE;
    case (in_q.cmd)
      tspq_pkg::CMD_ADD: begin
        if (q_status.full) begin
          res_d.add_status = tspq_pkg::ADD_FULL;
        end else begin
          push             = fire;
          res_d.add_status = tspq_pkg::ADD_OK;
        end
      end
      tspq_pkg::CMD_TICK: begin
        elapsed_d = elapsed_inc;
        if (q_status.nonempty && (elapsed_inc >= cur_delay_q)) begin
          pop                 = fire;
          elapsed_d           = '0;
          cur_delay_d         = head.delay;
          res_d.start_valid   = 1'b1;
          res_d.start_address = head.addr;
        end
      end
      tspq_pkg::CMD_STOP: begin
        res_d.stop_all = 1'b1;
      end
      default: begin
      end
    endcase
    res_d.queue_nonempty = push || (q_status.nonempty && !(pop && q_status.last));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q   <= '0;
      cur_delay_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (fire) begin
        elapsed_q   <= elapsed_d;
        cur_delay_q <= cur_delay_d;
        out_vld_q   <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res_d;
    end
  end

  tspq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (in_q.entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(tspq_pkg::OUT_TDATA_W - tspq_pkg::RESULT_W)'(0), out_q};

  // A full queue always reports entries waiting.
  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full |-> q_status.nonempty)
    else $error("queue full while empty");

  // A result without a started sound carries a zero address.
  a_start_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.start_valid) |-> (out_q.start_address == '0))
    else $error("start address set without start");

  // Starting a sound restarts the elapsed count.
  a_pop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (elapsed_q == '0))
    else $error("elapsed count not cleared on start");

  // Pushes and pops only happen when a processed item commits.
  a_update_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push || pop) |-> (fire && !(push && pop)))
    else $error("queue update without committed item");

endmodule
